/* design/ftrb_pkg.sv */
// ftrb_pkg: command codes, field widths and word layouts for the trace ring buffer
// no dependencies; imported by the top level and its checker
package ftrb_pkg;

	localparam int FUNC_W        = 3;
	localparam int PAYLOAD_W_MAX = 64;
	localparam int MARKER_W      = 8;
	localparam int READ_INDEX_W  = 10;
	localparam int HELD_COUNT_W  = 11;

	localparam logic [FUNC_W-1:0] FUNC_PUSH   = 3'd0;
	localparam logic [FUNC_W-1:0] FUNC_MARKER = 3'd1;
	localparam logic [FUNC_W-1:0] FUNC_FREEZE = 3'd2;
	localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 3'd3;
	localparam logic [FUNC_W-1:0] FUNC_READ   = 3'd4;

	localparam logic [MARKER_W-1:0] MARK_NONE = 8'd0;

	// input word layout
	localparam int IN_PAYLOAD_LSB = 0;
	localparam int IN_MARKER_LSB  = IN_PAYLOAD_LSB + PAYLOAD_W_MAX;
	localparam int IN_MVALUE_LSB  = IN_MARKER_LSB + MARKER_W;
	localparam int IN_INDEX_LSB   = IN_MVALUE_LSB + MARKER_W;
	localparam int IN_USED_W      = IN_INDEX_LSB + READ_INDEX_W;
	localparam int S_TDATA_W      = ((IN_USED_W + 7) / 8) * 8;

	// output word layout
	localparam int OUT_OK_LSB      = 0;
	localparam int OUT_PAYLOAD_LSB = OUT_OK_LSB + 1;
	localparam int OUT_MARKER_LSB  = OUT_PAYLOAD_LSB + PAYLOAD_W_MAX;
	localparam int OUT_COUNT_LSB   = OUT_MARKER_LSB + MARKER_W;
	localparam int OUT_FROZEN_LSB  = OUT_COUNT_LSB + HELD_COUNT_W;
	localparam int OUT_USED_W      = OUT_FROZEN_LSB + 1;
	localparam int M_TDATA_W       = ((OUT_USED_W + 7) / 8) * 8;

endpackage

/* design/ftrb_store.sv */
// ftrb_store: trace entry memory, one write port and one registered read port
// no dependencies; instantiated by freezable_trace_ring_buffer
module ftrb_store #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 72
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read data holds until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* design/freezable_trace_ring_buffer.sv */
// freezable_trace_ring_buffer: circular trace store with marker, freeze and clear commands
// depends on ftrb_pkg and ftrb_store
//
//   channel | dir | tdata                                   | tuser
//   s_*     | in  | payload, entry marker, marker value, idx | func
//   m_*     | out | ok, payload, marker, held count, frozen  | -
//
// one word accepted per cycle unless the input stalls; each result goes via the s1 and s2 registers.
// head, count, freeze flag and pending marker update at acceptance; the entry memory is
// touched at most once per word (unfrozen push writes, a hit reads); read data is registered.
// a push followed by a read of the same entry sees the new data with no extra wait.
// a result stage and an output register decouple the sides; input stalls only when both
// hold words and the output is stalled. reset clears control state only, no memory sweep.
module freezable_trace_ring_buffer #(
	parameter int DEPTH         = 1024,
	parameter int PAYLOAD_WIDTH = 64
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// payload, entry_marker, marker_value, read_index, zero pad
	input  logic [ftrb_pkg::S_TDATA_W-1:0] s_tdata,
	// func
	input  logic [ftrb_pkg::FUNC_W-1:0]    s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// read_ok, read_payload, read_marker, held_count, is_frozen, zero pad
	output logic [ftrb_pkg::M_TDATA_W-1:0] m_tdata
);

	import ftrb_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int XW = (CW > READ_INDEX_W) ? CW : READ_INDEX_W;
	localparam int MW = PAYLOAD_WIDTH + MARKER_W;

	logic [FUNC_W-1:0]        func;
	logic [PAYLOAD_W_MAX-1:0] in_payload;
	logic [MARKER_W-1:0]      in_marker;
	logic [MARKER_W-1:0]      in_mvalue;
	logic [READ_INDEX_W-1:0]  in_index;

	assign func       = s_tuser;
	assign in_payload = s_tdata[IN_PAYLOAD_LSB +: PAYLOAD_W_MAX];
	assign in_marker  = s_tdata[IN_MARKER_LSB +: MARKER_W];
	assign in_mvalue  = s_tdata[IN_MVALUE_LSB +: MARKER_W];
	assign in_index   = s_tdata[IN_INDEX_LSB +: READ_INDEX_W];

	logic [AW-1:0]       head_q;
	logic [CW-1:0]       count_q;
	logic                frozen_q;
	logic [MARKER_W-1:0] pend_q;

	logic [AW-1:0]       head_n;
	logic [CW-1:0]       count_n;
	logic                frozen_n;
	logic [MARKER_W-1:0] pend_n;

	logic v_s1, ok_s1, frz_s1;
	logic [CW-1:0] cnt_s1;
	logic v_s2, ok_s2, frz_s2;
	logic [CW-1:0]            cnt_s2;
	logic [PAYLOAD_W_MAX-1:0] pay_s2;
	logic [MARKER_W-1:0]      mark_s2;

	logic s_acc, adv1;
	logic hit, full, push_go, ok_n, wr_en, rd_en;
	logic [XW-1:0] idx_x;
	logic [AW:0]   sum, phys;
	logic [AW-1:0] rd_addr, head_inc;
	logic [MARKER_W-1:0] wmarker;
	logic [MW-1:0] wdata, rdata;

	assign adv1     = !v_s2 || m_tready;
	assign s_tready = !v_s1 || adv1;
	assign s_acc    = s_tvalid && s_tready;

	// logical to physical index; oldest entry sits at the head once the buffer is full
	assign idx_x = XW'(in_index);
	assign hit   = idx_x < XW'(count_q);
	assign full  = count_q == CW'(DEPTH);
	assign sum   = {1'b0, head_q} + {1'b0, idx_x[AW-1:0]};
	assign phys  = (sum >= (AW + 1)'(DEPTH)) ? sum - (AW + 1)'(DEPTH) : sum;
	assign rd_addr = full ? phys[AW-1:0] : idx_x[AW-1:0];

	assign head_inc = (head_q == AW'(DEPTH - 1)) ? '0 : head_q + AW'(1);
	assign push_go  = (func == FUNC_PUSH) && !frozen_q;
	assign ok_n     = (func == FUNC_READ) && hit;
	assign wr_en    = s_acc && push_go;
	assign rd_en    = s_acc && ok_n;
	assign wmarker  = (pend_q != MARK_NONE) ? pend_q : in_marker;
	assign wdata    = {wmarker, PAYLOAD_WIDTH'(in_payload)};

	always_comb begin
		head_n   = head_q;
		count_n  = count_q;
		frozen_n = frozen_q;
		pend_n   = pend_q;
		unique case (func)
			FUNC_PUSH: begin
				if (!frozen_q) begin
					head_n = head_inc;
					pend_n = MARK_NONE;
					if (!full) begin
						count_n = count_q + CW'(1);
					end
				end
			end
			FUNC_MARKER: begin
				pend_n = in_mvalue;
			end
			FUNC_FREEZE: begin
				frozen_n = 1'b1;
			end
			FUNC_CLEAR: begin
				frozen_n = 1'b0;
				head_n   = '0;
				count_n  = '0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q   <= '0;
			count_q  <= '0;
			frozen_q <= 1'b0;
			pend_q   <= MARK_NONE;
		end else if (s_acc) begin
			head_q   <= head_n;
			count_q  <= count_n;
			frozen_q <= frozen_n;
			pend_q   <= pend_n;
		end
	end

	ftrb_store #(
		.DEPTH (DEPTH),
		.WIDTH (MW)
	) u_store (
		.clk   (clk),
		.we    (wr_en),
		.waddr (head_q),
		.wdata (wdata),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (s_acc) begin
				v_s1 <= 1'b1;
			end else if (adv1) begin
				v_s1 <= 1'b0;
			end
			if (v_s1 && adv1) begin
				v_s2 <= 1'b1;
			end else if (m_tready) begin
				v_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_acc) begin
			ok_s1  <= ok_n;
			cnt_s1 <= count_n;
			frz_s1 <= frozen_n;
		end
		if (v_s1 && adv1) begin
			ok_s2   <= ok_s1;
			cnt_s2  <= cnt_s1;
			frz_s2  <= frz_s1;
			pay_s2  <= ok_s1 ? PAYLOAD_W_MAX'(rdata[PAYLOAD_WIDTH-1:0]) : '0;
			mark_s2 <= ok_s1 ? rdata[MW-1 -: MARKER_W] : MARK_NONE;
		end
	end

	assign m_tvalid = v_s2;
	assign m_tdata  = {{(M_TDATA_W - OUT_USED_W){1'b0}}, frz_s2, HELD_COUNT_W'(cnt_s2),
		mark_s2, pay_s2, ok_s2};

endmodule

/* design/ftrb_checker.sv */
// ftrb_checker: port-level checks on the trace ring buffer results
// depends on ftrb_pkg; bound to freezable_trace_ring_buffer below
module ftrb_checker #(
	parameter int DEPTH = 1024
) (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [ftrb_pkg::M_TDATA_W-1:0] m_tdata
);

	import ftrb_pkg::*;

	logic                     ok;
	logic [PAYLOAD_W_MAX-1:0] pay;
	logic [MARKER_W-1:0]      mark;
	logic [HELD_COUNT_W-1:0]  cnt;

	assign ok   = m_tdata[OUT_OK_LSB];
	assign pay  = m_tdata[OUT_PAYLOAD_LSB +: PAYLOAD_W_MAX];
	assign mark = m_tdata[OUT_MARKER_LSB +: MARKER_W];
	assign cnt  = m_tdata[OUT_COUNT_LSB +: HELD_COUNT_W];

	// a stalled result word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result word changed while stalled");

	// failed read or other command returns no entry data
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !ok |-> pay == '0 && mark == MARK_NONE)
		else $error("entry data without a successful read");

	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (DEPTH >= 2047) || (int'(cnt) <= DEPTH))
		else $error("held count above depth");

	// a read can only hit a non-empty buffer
	a_hit: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && ok |-> (cnt != '0) || (DEPTH >= 2047))
		else $error("read hit with empty buffer");

endmodule

bind freezable_trace_ring_buffer ftrb_checker #(
	.DEPTH (DEPTH)
) u_ftrb_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
